[sv/asa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the audible source attenuation block.
// Used by asa_ctrl, asa_dp and audible_source_attenuation_top_k.
package asa_pkg;

    localparam int MAX_VOICES = 24;
    localparam int ID_BITS    = 16;
    localparam int CNT_W      = $clog2(MAX_VOICES + 1);

    localparam int COORD_W = 24;
    localparam int REACH_W = 23;
    localparam int VOL_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUNDS_EN   = 3'd4;

    // Item kinds
    localparam logic ACT_MUSIC = 1'b0;
    localparam logic ACT_SOUND = 1'b1;

    // Q0.16 gains
    localparam logic [VOL_W-1:0] GAIN_MUSIC = 16'd47186;
    localparam logic [VOL_W-1:0] GAIN_SOUND = 16'd56361;

    // Iteration counts of the multicycle steps
    localparam int SQ_STEPS = 3;
    localparam int RT_STEPS = 25;
    localparam int DV_STEPS = 17;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sq_step;
        logic rt_init;
        logic rt_step;
        logic dv_init;
        logic dv_step;
        logic mul_t2;
        logic mul_s;
        logic mul_vol;
        logic ins;
        logic out_music;
        logic out_pop;
        logic out_mark;
    } asa_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fin;
        logic sound;
        logic audible;
        logic count_zero;
    } asa_stat_t;

endpackage

[sv/asa_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences distance, square root, division, gain, store and output steps.
// Depends on asa_pkg.
module asa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  asa_pkg::asa_stat_t  stat,
    output asa_pkg::asa_cmd_t   cmd
);
    import asa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_RTI  = 4'd2;
    localparam logic [3:0] S_RT   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DV   = 4'd5;
    localparam logic [3:0] S_M1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_M3   = 4'd8;
    localparam logic [3:0] S_PUT  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_POP  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQ_STEPS - 1))
                    state_next = S_RTI;
            end
            S_RTI:
            begin
                cmd.rt_init = 1'b1;
                cnt_next    = '0;
                state_next  = S_RT;
            end
            S_RT:
            begin
                cmd.rt_step = 1'b1;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'(RT_STEPS - 1))
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                cnt_next = '0;
                if (stat.audible)
                begin
                    cmd.dv_init = 1'b1;
                    state_next  = S_DV;
                end
                else
                    state_next = S_FIN;
            end
            S_DV:
            begin
                cmd.dv_step = 1'b1;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DV_STEPS - 1))
                    state_next = S_M1;
            end
            S_M1:
            begin
                cmd.mul_t2 = 1'b1;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.mul_s  = 1'b1;
                state_next = S_M3;
            end
            S_M3:
            begin
                cmd.mul_vol = 1'b1;
                state_next  = S_PUT;
            end
            S_PUT:
            begin
                if (stat.sound)
                begin
                    cmd.ins    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.out_music = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_FIN:
            begin
                if (!stat.fin)
                    state_next = S_IDLE;
                else if (!stat.count_zero)
                    state_next = S_POP;
                else
                begin
                    cmd.out_mark = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_POP:
            begin
                cmd.out_pop = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (stat.fin && !stat.count_zero)
                        state_next = S_POP;
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // No item taken while a result is on offer
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output both open");

    // An offered result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before accept");

    // Iteration counter stays within the longest step
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'(RT_STEPS))
        else $error("iteration counter overrun");

endmodule

[sv/asa_dp.sv]
`timescale 1ns / 1ps
// Datapath: listener registers, distance, sqrt, divide, smoothstep, ranked store.
// Depends on asa_pkg.
module asa_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [asa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [asa_pkg::COORD_W-1:0]          cfg_data,
    input  logic                                 action,
    input  logic [asa_pkg::ID_BITS-1:0]          source_id,
    input  logic signed [asa_pkg::COORD_W-1:0]   min_x,
    input  logic signed [asa_pkg::COORD_W-1:0]   min_y,
    input  logic signed [asa_pkg::COORD_W-1:0]   min_z,
    input  logic signed [asa_pkg::COORD_W-1:0]   max_x,
    input  logic signed [asa_pkg::COORD_W-1:0]   max_y,
    input  logic signed [asa_pkg::COORD_W-1:0]   max_z,
    input  logic [asa_pkg::REACH_W-1:0]          reach,
    input  logic                                 final_item,
    input  asa_pkg::asa_cmd_t                    cmd,
    output asa_pkg::asa_stat_t                   stat,
    output logic [asa_pkg::ID_BITS-1:0]          track_id,
    output logic [asa_pkg::VOL_W-1:0]            loudness,
    output logic                                 is_music,
    output logic                                 has_track,
    output logic                                 final_result
);
    import asa_pkg::*;

    // Distance from listener to box on one axis; a point is a box with lo == hi
    function automatic logic [COORD_W-1:0] axis_gap(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic                      box
    );
        logic signed [COORD_W:0] pe, lo, hi, d;
        lo = (COORD_W+1)'(a);
        hi = (COORD_W+1)'(a);
        if (box && (b < a))
            lo = (COORD_W+1)'(b);
        if (box && (b > a))
            hi = (COORD_W+1)'(b);
        pe = (COORD_W+1)'(p);
        if (pe < lo)
            d = lo - pe;
        else if (pe > hi)
            d = pe - hi;
        else
            d = '0;
        return d[COORD_W-1:0];
    endfunction

    // Configuration
    logic signed [COORD_W-1:0] lx_reg, ly_reg, lz_reg;
    logic                      men_reg, sen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg  <= '0;
            ly_reg  <= '0;
            lz_reg  <= '0;
            men_reg <= 1'b1;
            sen_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LISTENER_X: lx_reg  <= cfg_data;
                CFG_LISTENER_Y: ly_reg  <= cfg_data;
                CFG_LISTENER_Z: lz_reg  <= cfg_data;
                CFG_MUSIC_EN:   men_reg <= cfg_data[0];
                CFG_SOUNDS_EN:  sen_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Item registers and arithmetic state
    logic                 sound_reg, fin_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [REACH_W-1:0]   reach_reg;
    logic [COORD_W-1:0]   gx_reg, gy_reg, gz_reg;
    logic [49:0]          acc_reg;
    logic [25:0]          rem_reg;
    logic [24:0]          root_reg;
    logic [23:0]          drem_reg;
    logic [16:0]          quo_reg;
    logic [32:0]          t2_reg;
    logic [16:0]          s_reg;
    logic [VOL_W-1:0]     vol_reg;

    logic [27:0] rt_rem, rt_trial;
    logic        rt_ge;
    logic        dv_ge;
    logic [23:0] dv_sub;
    logic [17:0] s_w;
    logic [50:0] s_prod;
    logic [16:0] f_val;
    logic [32:0] v_prod;
    logic [VOL_W-1:0] gain;

    always_comb
    begin
        rt_rem   = {rem_reg, acc_reg[49:48]};
        rt_trial = {1'b0, root_reg, 2'b01};
        rt_ge    = (rt_rem >= rt_trial);
        dv_ge    = (drem_reg >= {1'b0, reach_reg});
        dv_sub   = dv_ge ? (drem_reg - {1'b0, reach_reg}) : drem_reg;
        s_w      = 18'd196608 - {quo_reg, 1'b0};
        s_prod   = t2_reg * s_w;
        f_val    = 17'd65536 - s_reg;
        gain     = sound_reg ? GAIN_SOUND : GAIN_MUSIC;
        v_prod   = gain * f_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sound_reg <= action;
            fin_reg   <= final_item;
            id_reg    <= source_id;
            reach_reg <= reach;
            gx_reg    <= axis_gap(lx_reg, min_x, max_x, action == ACT_MUSIC);
            gy_reg    <= axis_gap(ly_reg, min_y, max_y, action == ACT_MUSIC);
            gz_reg    <= axis_gap(lz_reg, min_z, max_z, action == ACT_MUSIC);
            acc_reg   <= '0;
        end
        // Sum of squares, one axis a cycle
        if (cmd.sq_step)
        begin
            acc_reg <= acc_reg + 50'(gx_reg * gx_reg);
            gx_reg  <= gy_reg;
            gy_reg  <= gz_reg;
        end
        if (cmd.rt_init)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        // Integer square root, one result bit a cycle
        if (cmd.rt_step)
        begin
            acc_reg <= {acc_reg[47:0], 2'b00};
            if (rt_ge)
            begin
                rem_reg  <= 26'(rt_rem - rt_trial);
                root_reg <= {root_reg[23:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rt_rem[25:0];
                root_reg <= {root_reg[23:0], 1'b0};
            end
        end
        if (cmd.dv_init)
        begin
            drem_reg <= {1'b0, root_reg[22:0]};
            quo_reg  <= '0;
        end
        // Restoring division d * 2^16 / reach, one quotient bit a cycle
        if (cmd.dv_step)
        begin
            drem_reg <= {dv_sub[22:0], 1'b0};
            quo_reg  <= {quo_reg[15:0], dv_ge};
        end
        if (cmd.mul_t2)
            t2_reg <= 33'(quo_reg * quo_reg);
        if (cmd.mul_s)
            s_reg <= (s_prod[50:32] > 19'd65536) ? 17'd65536 : s_prod[48:32];
        if (cmd.mul_vol)
            vol_reg <= v_prod[31:16];
    end

    // Ranked store: a row of entries, loudest at index 0
    logic [ID_BITS-1:0] ent_id [MAX_VOICES];
    logic [VOL_W-1:0]   ent_vol[MAX_VOICES];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [MAX_VOICES-1:0] keep;

    always_comb
    begin
        for (int i = 0; i < MAX_VOICES; i++)
            keep[i] = (CNT_W'(i) < count_reg) && (ent_vol[i] >= vol_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins && !keep[MAX_VOICES-1])
        begin
            for (int i = 0; i < MAX_VOICES; i++)
            begin
                if (!keep[i])
                begin
                    if (i == 0)
                    begin
                        ent_id[i]  <= id_reg;
                        ent_vol[i] <= vol_reg;
                    end
                    else if (keep[(i == 0) ? 0 : i-1])
                    begin
                        ent_id[i]  <= id_reg;
                        ent_vol[i] <= vol_reg;
                    end
                    else
                    begin
                        ent_id[i]  <= ent_id[(i == 0) ? 0 : i-1];
                        ent_vol[i] <= ent_vol[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
        else if (cmd.out_pop)
        begin
            for (int i = 0; i < MAX_VOICES - 1; i++)
            begin
                ent_id[i]  <= ent_id[i+1];
                ent_vol[i] <= ent_vol[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins && !keep[MAX_VOICES-1] && (count_reg != CNT_W'(MAX_VOICES)))
            count_next = count_reg + CNT_W'(1);
        else if (cmd.out_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_music)
        begin
            track_id     <= id_reg;
            loudness     <= vol_reg;
            is_music     <= 1'b1;
            has_track    <= 1'b1;
            final_result <= fin_reg && (count_reg == '0);
        end
        else if (cmd.out_pop)
        begin
            track_id     <= ent_id[0];
            loudness     <= ent_vol[0];
            is_music     <= 1'b0;
            has_track    <= 1'b1;
            final_result <= (count_reg == CNT_W'(1));
        end
        else if (cmd.out_mark)
        begin
            track_id     <= '0;
            loudness     <= '0;
            is_music     <= 1'b0;
            has_track    <= 1'b0;
            final_result <= 1'b1;
        end
    end

    // Status
    always_comb
    begin
        stat.fin        = fin_reg;
        stat.sound      = sound_reg;
        stat.count_zero = (count_reg == '0);
        stat.audible    = (sound_reg ? sen_reg : men_reg) && (reach_reg != '0)
                          && (root_reg <= {2'b00, reach_reg});
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VOICES))
        else $error("store count above capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_pop |-> count_reg != '0)
        else $error("pop from empty store");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_pop |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not shrink store");

endmodule

[sv/audible_source_attenuation_top_k.sv]
`timescale 1ns / 1ps
// Top level: audible source attenuation with a ranked store of sound emitters.
// Depends on asa_pkg, asa_ctrl and asa_dp.
//
// One item at a time. A dropped item passes through the squared gaps, the
// bit-serial square root and the check; an audible item goes on through the
// bit-serial divider, the smoothstep and gain multiplies and the store update
// or music result. Music results and the store drain come out one item per accept.
// Configuration is to be written only while the block is idle (in_ready high);
// the user is bound by this, the block itself does not enforce it.
module audible_source_attenuation_top_k (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [asa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [asa_pkg::COORD_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [asa_pkg::ID_BITS-1:0]          source_id,
    input  logic signed [asa_pkg::COORD_W-1:0]   min_x,
    input  logic signed [asa_pkg::COORD_W-1:0]   min_y,
    input  logic signed [asa_pkg::COORD_W-1:0]   min_z,
    input  logic signed [asa_pkg::COORD_W-1:0]   max_x,
    input  logic signed [asa_pkg::COORD_W-1:0]   max_y,
    input  logic signed [asa_pkg::COORD_W-1:0]   max_z,
    input  logic [asa_pkg::REACH_W-1:0]          reach,
    input  logic                                 final_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [asa_pkg::ID_BITS-1:0]          track_id,
    output logic [asa_pkg::VOL_W-1:0]            loudness,
    output logic                                 is_music,
    output logic                                 has_track,
    output logic                                 final_result
);
    import asa_pkg::*;

    asa_cmd_t  cmd;
    asa_stat_t stat;

    asa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    asa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .source_id    (source_id),
        .min_x        (min_x),
        .min_y        (min_y),
        .min_z        (min_z),
        .max_x        (max_x),
        .max_y        (max_y),
        .max_z        (max_z),
        .reach        (reach),
        .final_item   (final_item),
        .cmd          (cmd),
        .stat         (stat),
        .track_id     (track_id),
        .loudness     (loudness),
        .is_music     (is_music),
        .has_track    (has_track),
        .final_result (final_result)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for audible_source_attenuation_top_k: random and directed music/sound items,
// a scoreboard of predicted tracks, random stalls on both channels.
// Depends on asa_pkg and the RTL of the block.
module tb;
    import asa_pkg::*;

    typedef struct packed {
        logic        action;
        logic [15:0] source_id;
        logic [23:0] min_x, min_y, min_z, max_x, max_y, max_z;
        logic [22:0] reach;
        logic        final_item;
    } source_item_t;

    typedef struct packed {
        logic [15:0] track_id;
        logic [15:0] loudness;
        logic        is_music;
        logic        has_track;
        logic        final_result;
    } track_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    source_item_t cur = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] track_id, loudness;
    logic is_music, has_track, final_result;

    audible_source_attenuation_top_k u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .action(cur.action), .source_id(cur.source_id),
        .min_x(cur.min_x), .min_y(cur.min_y), .min_z(cur.min_z),
        .max_x(cur.max_x), .max_y(cur.max_y), .max_z(cur.max_z),
        .reach(cur.reach), .final_item(cur.final_item),
        .out_valid(out_valid), .out_ready(out_ready), .track_id(track_id),
        .loudness(loudness), .is_music(is_music), .has_track(has_track),
        .final_result(final_result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic signed [23:0] lis_x, lis_y, lis_z;
    logic music_on, sounds_on;
    logic [15:0] voice_id[MAX_VOICES];
    logic [15:0] voice_vol[MAX_VOICES];
    int voice_count;

    source_item_t pending_items[$];
    track_t expected_tracks[$];
    int errors = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    bit accepted_in = 0;

    function automatic void add_item(source_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void add_track(track_t tr);
        expected_tracks.insert(expected_tracks.size(), tr);
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] box_gap(logic signed [23:0] p, logic signed [23:0] a,
                                            logic signed [23:0] b);
        logic signed [25:0] lo, hi;
        lo = (a < b) ? 26'(a) : 26'(b);
        hi = (a < b) ? 26'(b) : 26'(a);
        if (p < lo) return 64'(lo - 26'(p));
        if (p > hi) return 64'(26'(p) - hi);
        return 0;
    endfunction

    // returns -1 when inaudible, else the Q0.16 volume
    function automatic int fade_volume(logic [63:0] gx, logic [63:0] gy, logic [63:0] gz,
                                       logic [22:0] r, logic [15:0] gain);
        logic [63:0] d, t, s;
        if (r == 0) return -1;
        d = isqrt(gx * gx + gy * gy + gz * gz);
        if (d > r) return -1;
        t = (d << 16) / r;
        if (t > 65536) t = 65536;
        s = ((t * t) * (3 * 65536 - 2 * t)) >> 32;
        if (s > 65536) s = 65536;
        return int'((64'(gain) * (65536 - s)) >> 16);
    endfunction

    task automatic predict_tracks(source_item_t it);
        int v, pos, n;
        n = 0;
        if (it.action == ACT_MUSIC)
        begin
            v = music_on ? fade_volume(box_gap(lis_x, it.min_x, it.max_x),
                box_gap(lis_y, it.min_y, it.max_y), box_gap(lis_z, it.min_z, it.max_z),
                it.reach, GAIN_MUSIC) : -1;
            if (v >= 0)
            begin
                add_track({it.source_id, 16'(v), 1'b1, 1'b1, 1'b0});
                n++;
            end
        end
        else
        begin
            v = sounds_on ? fade_volume(box_gap(lis_x, it.min_x, it.min_x),
                box_gap(lis_y, it.min_y, it.min_y), box_gap(lis_z, it.min_z, it.min_z),
                it.reach, GAIN_SOUND) : -1;
            if (v >= 0)
            begin
                pos = 0;
                while (pos < voice_count && voice_vol[pos] >= v) pos++;
                if (pos < MAX_VOICES)
                begin
                    if (voice_count < MAX_VOICES) voice_count++;
                    for (int i = voice_count - 1; i > pos; i--)
                    begin
                        voice_id[i] = voice_id[i-1];
                        voice_vol[i] = voice_vol[i-1];
                    end
                    voice_id[pos] = it.source_id;
                    voice_vol[pos] = 16'(v);
                end
            end
        end
        if (it.final_item)
        begin
            for (int i = 0; i < voice_count; i++)
            begin
                add_track({voice_id[i], voice_vol[i], 1'b0, 1'b1, 1'b0});
                n++;
            end
            voice_count = 0;
            if (n == 0)
                add_track({16'd0, 16'd0, 1'b0, 1'b0, 1'b1});
            else
                expected_tracks[$].final_result = 1'b1;
        end
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // driver: offers the next queued item, idles at random between items
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || accepted_in)
            begin
                if (send_gap > 0 || pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end
                else
                begin
                    cur <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
                end
            end
        end
    end

    // input acceptance and prediction at the rising edge
    always @(posedge clk)
    begin
        accepted_in <= 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            predict_tracks(cur);
            accepted_in <= 1'b1;
        end
    end

    // receiver ready, with random stalls and one long hold-off at the first result
    int recv_gap = 0;
    bit hold_done = 0;
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (!hold_done && rst_n && out_valid)
        begin
            out_ready <= 1'b0;
            hold_off <= 600;
            hold_done <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
    end

    // monitor: compare each track with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tracks.size() == 0)
            begin
                $display("%0t: unexpected track id=%0d vol=%0d", $time, track_id, loudness);
                errors++;
            end
            else
            begin
                track_t e;
                e = expected_tracks.pop_front();
                if (e != {track_id, loudness, is_music, has_track, final_result})
                begin
                    $display("%0t: mismatch expected id=%0d vol=%0d mus=%0b has=%0b fin=%0b",
                        $time, e.track_id, e.loudness, e.is_music, e.has_track,
                        e.final_result);
                    $display("%0t:          actual id=%0d vol=%0d mus=%0b has=%0b fin=%0b",
                        $time, track_id, loudness, is_music, has_track, final_result);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no accept on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("audible_source_attenuation_top_k test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LISTENER_X: lis_x = val;
            CFG_LISTENER_Y: lis_y = val;
            CFG_LISTENER_Z: lis_z = val;
            CFG_MUSIC_EN:   music_on = val[0];
            CFG_SOUNDS_EN:  sounds_on = val[0];
            default: ;
        endcase
    endtask

    // wait until all queued items are accepted and all tracks have come out
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_tracks.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [23:0] rnd_coord(int span);
        if ($urandom_range(0, 9) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic source_item_t rnd_item(logic [23:0] lx, logic [23:0] ly,
                                              logic [23:0] lz, bit fin);
        source_item_t it;
        int span;
        span = ($urandom_range(0, 3) == 0) ? 20000 : 3000;
        it.action = 1'($urandom);
        it.source_id = 16'($urandom);
        it.min_x = lx + rnd_coord(span);
        it.min_y = ly + rnd_coord(span);
        it.min_z = lz + rnd_coord(span);
        it.max_x = lx + rnd_coord(span);
        it.max_y = ly + rnd_coord(span);
        it.max_z = lz + rnd_coord(span);
        case ($urandom_range(0, 9))
            0: it.reach = 0;
            1: it.reach = 23'($urandom);
            default: it.reach = 23'($urandom_range(1, 8000));
        endcase
        it.final_item = fin;
        return it;
    endfunction

    function automatic source_item_t mk(logic act, logic [15:0] id, logic [23:0] x,
        logic [23:0] y, logic [23:0] z, logic [23:0] xx, logic [23:0] yy, logic [23:0] zz,
        logic [22:0] r, logic fin);
        return {act, id, x, y, z, xx, yy, zz, r, fin};
    endfunction

    initial
    begin
        lis_x = 0; lis_y = 0; lis_z = 0;
        music_on = 1; sounds_on = 1;
        voice_count = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, swapped corners, inside box, zero reach, empty final
        add_item(mk(ACT_MUSIC, 16'hFFFF, -24'sd100, -24'sd100, -24'sd100,
            24'sd100, 24'sd100, 24'sd100, 23'd500, 1'b0));
        add_item(mk(ACT_MUSIC, 16'h0001, 24'sd900, 24'sd50, 24'sd0,
            24'sd300, -24'sd50, 24'sd0, 23'd2000, 1'b0));
        add_item(mk(ACT_MUSIC, 16'h0002, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
            24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF, 1'b0));
        add_item(mk(ACT_MUSIC, 16'h0003, 24'sd10, 24'd0, 24'd0, 24'sd20, 24'd0, 24'd0,
            23'd0, 1'b0));
        add_item(mk(ACT_SOUND, 16'h0000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
            24'd0, 24'd0, 24'd0, 23'h7FFFFF, 1'b0));
        add_item(mk(ACT_SOUND, 16'h1234, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
            23'd1, 1'b0));
        add_item(mk(ACT_SOUND, 16'h5555, 24'sd100, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
            23'd400, 1'b0));
        add_item(mk(ACT_SOUND, 16'hAAAA, 24'sd100, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
            23'd400, 1'b0));
        add_item(mk(ACT_SOUND, 16'h0777, 24'h800000, 24'h800000, 24'h800000,
            24'd0, 24'd0, 24'd0, 23'h7FFFFF, 1'b0));
        add_item(mk(ACT_SOUND, 16'h0042, 24'sd500, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
            23'd400, 1'b1));
        add_item(mk(ACT_MUSIC, 16'h0009, 24'sd5000, 24'd0, 24'd0, 24'sd6000, 24'd0, 24'd0,
            23'd10, 1'b1));
        // a full store: 30 sounds, only the 24 loudest survive
        for (int i = 0; i < 30; i++)
            add_item(mk(ACT_SOUND, 16'(i), 24'($urandom_range(0, 3000)), 24'd0, 24'd0,
                24'd0, 24'd0, 24'd0, 23'd4000, i == 29));
        drain();

        // disabled kinds, extreme listener
        write_reg(CFG_MUSIC_EN, 24'd0);
        write_reg(CFG_SOUNDS_EN, 24'd0);
        write_reg(CFG_LISTENER_X, 24'h7FFFFF);
        write_reg(CFG_LISTENER_Y, 24'h800000);
        write_reg(CFG_LISTENER_Z, 24'h7FFFFF);
        for (int i = 0; i < 10; i++)
            add_item(rnd_item(lis_x, lis_y, lis_z, i == 9));
        drain();

        // random phases, several listener settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_MUSIC_EN, 24'(ph != 2));
            write_reg(CFG_SOUNDS_EN, 24'(ph != 3));
            write_reg(CFG_LISTENER_X, (ph == 5) ? 24'h800000 : 24'($urandom_range(0, 4000)));
            write_reg(CFG_LISTENER_Y, 24'($signed($urandom_range(0, 8000)) - 4000));
            write_reg(CFG_LISTENER_Z, (ph == 5) ? 24'h800000 : 24'($urandom));
            for (int i = 0; i < 45; i++)
                add_item(rnd_item(lis_x, lis_y, lis_z,
                    $urandom_range(0, 11) == 0 || i == 44));
            drain();
        end

        if (errors == 0)
            $display("audible_source_attenuation_top_k test passed");
        else
            $display("audible_source_attenuation_top_k test failed");
        $finish;
    end
endmodule
